// ----- rtl/ahdlc_pkg.sv -----
package ahdlc_pkg;

   localparam logic [7:0]  EscByte  = 8'h7D;
   localparam logic [7:0]  FlagByte = 8'h7E;
   localparam logic [7:0]  XorMask  = 8'h20;
   localparam logic [15:0] CrcSeed  = 16'hFFFF;
   localparam logic [15:0] CrcPoly  = 16'h8408;

   // worst case per transaction: escaped byte, two escaped fcs bytes, flag
   localparam int MaxSlots = 7;
   localparam int SlotIdxW = $clog2(MaxSlots + 1);

   typedef logic [SlotIdxW-1:0] slot_idx_type;

   typedef struct packed {
      logic [MaxSlots-1:0][7:0] slots;
      slot_idx_type             count;
   } frame_slots_type;

   // reflected crc-16-ccitt, one byte, lsb first
   function automatic logic [15:0] crc_advance(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == EscByte) || (b == FlagByte);
   endfunction

endpackage

// ----- rtl/ahdlc_expand.sv -----
module ahdlc_expand (
   input  logic [7:0]                payload_byte,
   input  logic                      end_of_packet,
   input  logic [15:0]               crc,
   output logic [15:0]               crc_next,
   output ahdlc_pkg::frame_slots_type frame
);
   import ahdlc_pkg::*;

   logic [15:0]  crc_mid;
   logic [15:0]  fcs;
   logic [7:0]   fcs_lo;
   logic [7:0]   fcs_hi;
   logic         esc_data;
   logic         esc_lo;
   logic         esc_hi;
   slot_idx_type pos_lo;
   slot_idx_type pos_hi;
   slot_idx_type pos_flag;

   assign crc_mid  = crc_advance(crc, payload_byte);
   assign fcs      = crc_mid ^ CrcSeed;
   assign fcs_lo   = fcs[7:0];
   assign fcs_hi   = fcs[15:8];
   assign esc_data = needs_escape(payload_byte);
   assign esc_lo   = needs_escape(fcs_lo);
   assign esc_hi   = needs_escape(fcs_hi);
   assign crc_next = end_of_packet ? CrcSeed : crc_mid;

   // start slot of each trailer piece
   assign pos_lo   = esc_data ? SlotIdxW'(2) : SlotIdxW'(1);
   assign pos_hi   = SlotIdxW'(pos_lo + (esc_lo ? SlotIdxW'(2) : SlotIdxW'(1)));
   assign pos_flag = SlotIdxW'(pos_hi + (esc_hi ? SlotIdxW'(2) : SlotIdxW'(1)));

   always_comb begin
      frame.slots = '0;
      if (esc_data) begin
         frame.slots[0] = EscByte;
         frame.slots[1] = payload_byte ^ XorMask;
      end else begin
         frame.slots[0] = payload_byte;
      end
      if (end_of_packet) begin
         if (esc_lo) begin
            frame.slots[pos_lo]                        = EscByte;
            frame.slots[SlotIdxW'(pos_lo + SlotIdxW'(1))] = fcs_lo ^ XorMask;
         end else begin
            frame.slots[pos_lo] = fcs_lo;
         end
         if (esc_hi) begin
            frame.slots[pos_hi]                        = EscByte;
            frame.slots[SlotIdxW'(pos_hi + SlotIdxW'(1))] = fcs_hi ^ XorMask;
         end else begin
            frame.slots[pos_hi] = fcs_hi;
         end
         frame.slots[pos_flag] = FlagByte;
         frame.count = SlotIdxW'(pos_flag + SlotIdxW'(1));
      end else begin
         frame.count = pos_lo;
      end
   end

endmodule

// ----- rtl/async_hdlc_frame_encoder.sv -----
// Async HDLC frame encoder: payload bytes enter one per transaction on req_, with req_tlast
// on the final byte of a packet. Each byte is sent on rsp_ as is, or as 0x7D then byte^0x20
// when it equals 0x7D or 0x7E. After the final byte the inverted reflected CRC-16-CCITT
// (seed 0xFFFF, poly 0x8408) follows low byte first, escaped the same way, then a closing
// 0x7E flag marked by rsp_tuser. rsp_tlast marks the last output byte caused by an input byte.
// Rate: an input byte expands to 1 or 2 output bytes when ordinary, 4 to 7 when it is the
// final byte of a packet; these leave one byte per cycle while rsp_tready is high. The
// whole expansion is built combinationally and loaded into a slot register; the next
// transaction is accepted in the same cycle the last slot of the previous one is taken, so
// a stream of unescaped bytes flows at one per cycle while rsp_tready stays high.
module async_hdlc_frame_encoder (
   input  logic       clock,
   input  logic       reset,
   // input byte stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] payload_byte
   input  logic       req_tlast,   // end_of_packet
   // framed line stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tlast,   // run_last
   output logic       rsp_tuser    // [0] frame_end
);
   import ahdlc_pkg::*;

   // running crc over the raw payload of the current packet
   logic [15:0]     crc_ff, crc_in;
   logic [15:0]     crc_next;

   // expanded output bytes of the transaction being sent
   frame_slots_type frame_ff, frame_in;
   frame_slots_type frame_new;
   logic            eop_ff, eop_in;
   slot_idx_type    idx_ff, idx_in;
   logic            valid_ff, valid_in;

   logic            req_accept;
   logic            rsp_accept;
   logic            at_last_slot;

   ahdlc_expand u_expand (
      .payload_byte  (req_tdata),
      .end_of_packet (req_tlast),
      .crc           (crc_ff),
      .crc_next      (crc_next),
      .frame         (frame_new)
   );

   assign at_last_slot = (idx_ff == SlotIdxW'(frame_ff.count - SlotIdxW'(1)));
   assign rsp_accept   = rsp_tvalid && rsp_tready;
   // free when empty, or when the final slot leaves this cycle
   assign req_tready   = !valid_ff || (rsp_tready && at_last_slot);
   assign req_accept   = req_tvalid && req_tready;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = frame_ff.slots[idx_ff];
   assign rsp_tlast  = at_last_slot;
   assign rsp_tuser  = eop_ff && at_last_slot;

   always_comb begin
      crc_in   = crc_ff;
      frame_in = frame_ff;
      eop_in   = eop_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (rsp_accept) begin
         if (at_last_slot) begin
            valid_in = 1'b0;
         end else begin
            idx_in = SlotIdxW'(idx_ff + SlotIdxW'(1));
         end
      end
      if (req_accept) begin
         crc_in   = crc_next;
         frame_in = frame_new;
         eop_in   = req_tlast;
         idx_in   = '0;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CrcSeed;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         crc_ff   <= crc_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      eop_ff   <= eop_in;
   end

   // checks

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < frame_ff.count))
      else $error("slot index beyond slot count");

   a_reseed_on_eop: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (crc_ff == CrcSeed))
      else $error("crc not reseeded after final byte");

   a_flag_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tlast && rsp_tdata == FlagByte))
      else $error("closing flag not on last slot");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> req_tready)
      else $error("input stalled while empty");

endmodule
